// ----- hdl/rlsd_pkg.sv -----
// Package for the run-length stream decoder.
// Holds phase and result-kind enums, controller/datapath command and status structs,
// and fixed stream constants. No dependencies.
package rlsd_pkg;

  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned HdrIdxW     = 4;
  localparam int unsigned RunFlagBit  = 7;
  localparam logic [31:0] StreamMagic = 32'h21494D46;
  localparam logic [HdrIdxW-1:0] MagicLastIdx = 4'd3;
  localparam logic [HdrIdxW-1:0] CountLastIdx = 4'd7;
  localparam logic [HdrIdxW-1:0] HdrLastIdx   = HdrIdxW'(HeaderBytes - 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_LITERAL,
    PH_REPEAT,
    PH_EMIT,
    PH_DONE,
    PH_LOCKED
  } phase_e;

  typedef enum logic [1:0] {
    OUT_BAD,
    OUT_DONE,
    OUT_LITERAL,
    OUT_REPEAT
  } out_kind_e;

  typedef struct packed {
    logic      hdr_step;
    logic      run_load;
    logic      lit_step;
    logic      rep_hold;
    logic      rep_step;
    logic      pkt_dec;
    logic      out_load;
    out_kind_e out_kind;
    logic      out_last;
    logic      out_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hdr_idx_magic;
    logic magic_ok;
    logic hdr_last;
    logic pkts_zero;
    logic last_packet;
    logic run_flag;
    logic lit_last;
    logic rep_last;
  } dp_status_t;

endpackage

// ----- hdl/rlsd_datapath.sv -----
// Datapath of the run-length stream decoder: header shifters, packet and run
// counters, held repeat byte and the output register.
// Depends on rlsd_pkg; driven by rlsd_ctrl.
module rlsd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_byte_i,
  input  logic                out_ready_i,
  input  rlsd_pkg::dp_cmd_t   cmd_i,
  output rlsd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output logic [7:0]          byte_a_o,
  output logic [7:0]          byte_b_o,
  output logic [1:0]          byte_count_o,
  output logic                run_last_o,
  output logic                stream_done_o,
  output logic                bad_magic_o
);
  import rlsd_pkg::*;

  logic [HdrIdxW-1:0] hdr_idx_q, hdr_idx_d;
  logic [31:0]        magic_q, magic_d;
  logic [31:0]        pkts_q, pkts_d;
  logic [7:0]         run_left_q, run_left_d;
  logic [7:0]         rep_byte_q, rep_byte_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         byte_a_q, byte_a_d;
  logic [7:0]         byte_b_q, byte_b_d;
  logic [1:0]         count_q, count_d;
  logic               last_q, last_d;
  logic               done_q, done_d;
  logic               bad_q, bad_d;
  logic [31:0]        magic_shift;
  logic               rep_pair;

  assign magic_shift = {in_byte_i, magic_q[31:8]};
  assign rep_pair    = run_left_q >= 8'd2;

  always_comb begin
    status_o.out_free      = !out_valid_q || out_ready_i;
    status_o.hdr_idx_magic = hdr_idx_q == MagicLastIdx;
    status_o.magic_ok      = magic_shift == StreamMagic;
    status_o.hdr_last      = hdr_idx_q == HdrLastIdx;
    status_o.pkts_zero     = pkts_q == 32'd0;
    status_o.last_packet   = pkts_q == 32'd1;
    status_o.run_flag      = in_byte_i[RunFlagBit];
    status_o.lit_last      = run_left_q == 8'd1;
    status_o.rep_last      = !(run_left_q > 8'd2);
  end

  always_comb begin
    hdr_idx_d  = hdr_idx_q;
    magic_d    = magic_q;
    pkts_d     = pkts_q;
    run_left_d = run_left_q;
    rep_byte_d = rep_byte_q;
    if (cmd_i.hdr_step) begin
      hdr_idx_d = status_o.hdr_last ? '0 : hdr_idx_q + 1'b1;
      if (!(hdr_idx_q > MagicLastIdx)) begin
        magic_d = magic_shift;
      end else if (!(hdr_idx_q > CountLastIdx)) begin
        pkts_d = {in_byte_i, pkts_q[31:8]};
      end
    end
    if (cmd_i.pkt_dec) begin
      pkts_d = pkts_q - 32'd1;
    end
    if (cmd_i.run_load) begin
      run_left_d = {1'b0, in_byte_i[6:0]} + 8'd1;
    end else if (cmd_i.lit_step) begin
      run_left_d = run_left_q - 8'd1;
    end else if (cmd_i.rep_step) begin
      run_left_d = run_left_q - (rep_pair ? 8'd2 : 8'd1);
    end
    if (cmd_i.rep_hold) begin
      rep_byte_d = in_byte_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    byte_a_d    = byte_a_q;
    byte_b_d    = byte_b_q;
    count_d     = count_q;
    last_d      = last_q;
    done_d      = done_q;
    bad_d       = bad_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      last_d      = cmd_i.out_last;
      done_d      = cmd_i.out_done;
      bad_d       = cmd_i.out_kind == OUT_BAD;
      unique case (cmd_i.out_kind)
        OUT_LITERAL: begin
          byte_a_d = in_byte_i;
          byte_b_d = 8'd0;
          count_d  = 2'd1;
        end
        OUT_REPEAT: begin
          byte_a_d = rep_byte_q;
          byte_b_d = rep_pair ? rep_byte_q : 8'd0;
          count_d  = rep_pair ? 2'd2 : 2'd1;
        end
        default: begin
          byte_a_d = 8'd0;
          byte_b_d = 8'd0;
          count_d  = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q   <= '0;
      magic_q     <= '0;
      pkts_q      <= '0;
      run_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_idx_q   <= hdr_idx_d;
      magic_q     <= magic_d;
      pkts_q      <= pkts_d;
      run_left_q  <= run_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_byte_q <= rep_byte_d;
    byte_a_q   <= byte_a_d;
    byte_b_q   <= byte_b_d;
    count_q    <= count_d;
    last_q     <= last_d;
    done_q     <= done_d;
    bad_q      <= bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign byte_a_o      = byte_a_q;
  assign byte_b_o      = byte_b_q;
  assign byte_count_o  = count_q;
  assign run_last_o    = last_q;
  assign stream_done_o = done_q;
  assign bad_magic_o   = bad_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> status_o.out_free)
    else $error("result loaded over a pending one");

  a_pkt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pkt_dec |-> !status_o.pkts_zero)
    else $error("packet count underflow");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (bad_q || count_q == 2'd0)) |-> (last_q && count_q == 2'd0))
    else $error("status result malformed");

  a_run_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lit_step || cmd_i.rep_step) |-> run_left_q != 8'd0)
    else $error("run counter stepped at zero");

endmodule

// ----- hdl/rlsd_ctrl.sv -----
// Controller of the run-length stream decoder: phase state machine issuing
// datapath commands and input handshake.
// Depends on rlsd_pkg; pairs with rlsd_datapath.
module rlsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rlsd_pkg::dp_status_t status_i,
  output rlsd_pkg::dp_cmd_t    cmd_o
);
  import rlsd_pkg::*;

  phase_e state_q, state_d;
  logic   acc;

  always_comb begin
    unique case (state_q)
      PH_HEADER, PH_CONTROL, PH_LITERAL, PH_REPEAT: in_ready_o = status_i.out_free;
      PH_EMIT:                                      in_ready_o = 1'b0;
      default:                                      in_ready_o = 1'b1;
    endcase
  end

  assign acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PH_HEADER: begin
        if (acc) begin
          if (status_i.hdr_idx_magic && !status_i.magic_ok) begin
            state_d = PH_LOCKED;
          end else if (status_i.hdr_last) begin
            state_d = status_i.pkts_zero ? PH_DONE : PH_CONTROL;
          end
        end
      end
      PH_CONTROL: begin
        if (acc) begin
          state_d = status_i.run_flag ? PH_REPEAT : PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        if (acc && status_i.lit_last) begin
          state_d = status_i.last_packet ? PH_DONE : PH_CONTROL;
        end
      end
      PH_REPEAT: begin
        if (acc) begin
          state_d = PH_EMIT;
        end
      end
      PH_EMIT: begin
        if (status_i.out_free && status_i.rep_last) begin
          state_d = status_i.last_packet ? PH_DONE : PH_CONTROL;
        end
      end
      default: state_d = state_q;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.out_kind = OUT_BAD;
    unique case (state_q)
      PH_HEADER: begin
        if (acc) begin
          cmd_o.hdr_step = 1'b1;
          if (status_i.hdr_idx_magic && !status_i.magic_ok) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = OUT_BAD;
            cmd_o.out_last = 1'b1;
          end else if (status_i.hdr_last && status_i.pkts_zero) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = OUT_DONE;
            cmd_o.out_last = 1'b1;
            cmd_o.out_done = 1'b1;
          end
        end
      end
      PH_CONTROL: begin
        cmd_o.run_load = acc;
      end
      PH_LITERAL: begin
        if (acc) begin
          cmd_o.lit_step = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_LITERAL;
          cmd_o.out_last = 1'b1;
          cmd_o.pkt_dec  = status_i.lit_last;
          cmd_o.out_done = status_i.lit_last && status_i.last_packet;
        end
      end
      PH_REPEAT: begin
        cmd_o.rep_hold = acc;
      end
      PH_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.rep_step = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OUT_REPEAT;
          cmd_o.out_last = status_i.rep_last;
          cmd_o.pkt_dec  = status_i.rep_last;
          cmd_o.out_done = status_i.rep_last && status_i.last_packet;
        end
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PH_EMIT |-> !in_ready_o)
    else $error("input taken during repeat output");

  a_locked_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PH_LOCKED |=> state_q == PH_LOCKED)
    else $error("left locked phase");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PH_DONE |=> (state_q == PH_DONE && !cmd_o.out_load))
    else $error("activity after done");

endmodule

// ----- hdl/run_length_stream_decoder.sv -----
// Run-length stream decoder, top level. A result is registered from the transaction that
// causes it. Control bytes give no result; a header byte gives one only on bad magic or
// zero packet count. Literal byte: one result. Repeat byte: taken, then sent by the repeat
// emit loop as up to 64 two-byte results (odd run: last has one byte), input held off.
// Reset (rst_ni, async, active low) returns to the header phase with counters cleared.
module run_length_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] byte_a, [15:8] byte_b, [17:16] byte_count
  output logic        m_axis_tlast_o,  // run_last
  output logic [1:0]  m_axis_tuser_o   // [0] stream_done, [1] bad_magic
);
  import rlsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [1:0] byte_count;
  logic       stream_done;
  logic       bad_magic;

  rlsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlsd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (s_axis_tdata_i),
    .out_ready_i   (m_axis_tready_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .byte_a_o      (byte_a),
    .byte_b_o      (byte_b),
    .byte_count_o  (byte_count),
    .run_last_o    (m_axis_tlast_o),
    .stream_done_o (stream_done),
    .bad_magic_o   (bad_magic)
  );

  assign m_axis_tdata_o = {6'd0, byte_count, byte_b, byte_a};
  assign m_axis_tuser_o = {bad_magic, stream_done};

endmodule
